>>> sv/dpfm_pkg.sv
// ----------------------------------------------------------------------------
// dpfm_pkg
// Shared field widths, stream layouts and helpers for the paging MMU.
// ----------------------------------------------------------------------------
package dpfm_pkg;

  // Port field widths
  localparam int PID_W   = 2;
  localparam int VPAGE_W = 3;
  localparam int OFF_W   = 12;
  localparam int PA_W    = 15;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Input transaction, lowest field in the lowest bits
  typedef struct packed {
    logic [IN_TDATA_W-PID_W-VPAGE_W-OFF_W-1:0] pad;
    logic [OFF_W-1:0]                          page_offset;
    logic [VPAGE_W-1:0]                        virtual_page;
    logic [PID_W-1:0]                          process_id;
  } in_item_t;

  // Result transaction, lowest field in the lowest bits
  typedef struct packed {
    logic [OUT_TDATA_W-PA_W-2-PID_W-VPAGE_W-1:0] pad;
    logic [VPAGE_W-1:0]                          evicted_page;
    logic [PID_W-1:0]                            evicted_process;
    logic                                        did_evict;
    logic                                        page_fault;
    logic [PA_W-1:0]                             physical_address;
  } out_item_t;

  // Index width for a store of n entries (at least one bit)
  function automatic int idx_width(input int n);
    int w;
    w = (n > 1) ? $clog2(n) : 1;
    return w;
  endfunction

endpackage

>>> sv/dpfm_table.sv
// ----------------------------------------------------------------------------
// dpfm_table
// Translation table: present bits in flops, frame numbers in a synchronous
// memory with registered read.
// ----------------------------------------------------------------------------
module dpfm_table #(
  parameter int NUM_ENTRIES = 32,
  parameter int FRAME_W     = 3
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       rd_en,
  input  logic [dpfm_pkg::idx_width(NUM_ENTRIES)-1:0] rd_addr,
  output logic                                       rd_present,
  output logic [FRAME_W-1:0]                         rd_frame,
  input  logic                                       wr_en,
  input  logic [dpfm_pkg::idx_width(NUM_ENTRIES)-1:0] wr_addr,
  input  logic [FRAME_W-1:0]                         wr_frame,
  input  logic                                       clr_en,
  input  logic [dpfm_pkg::idx_width(NUM_ENTRIES)-1:0] clr_addr
);
  import dpfm_pkg::*;

  logic [FRAME_W-1:0]     frame_mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] present_r;
  logic [NUM_ENTRIES-1:0] present_nxt;
  logic                   rd_present_r;
  logic [FRAME_W-1:0]     rd_frame_r;

  // Clear of the victim first, then set of the newly loaded entry
  always_comb begin
    present_nxt = present_r;
    if (clr_en) begin
      present_nxt[clr_addr] = 1'b0;
    end
    if (wr_en) begin
      present_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else begin
      present_r <= present_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_frame;
    end
    if (rd_en) begin
      rd_frame_r   <= frame_mem[rd_addr];
      rd_present_r <= present_r[rd_addr];
    end
  end

  assign rd_present = rd_present_r;
  assign rd_frame   = rd_frame_r;

endmodule

>>> sv/dpfm_owner.sv
// ----------------------------------------------------------------------------
// dpfm_owner
// Frame owner memory: process and page that hold each physical frame.
// Entries are undefined until their frame is first loaded.
// ----------------------------------------------------------------------------
module dpfm_owner #(
  parameter int NUM_FRAMES = 8,
  parameter int PROC_W     = 2,
  parameter int PAGE_W     = 3
) (
  input  logic                                      clk,
  input  logic                                      rd_en,
  input  logic [dpfm_pkg::idx_width(NUM_FRAMES)-1:0] rd_addr,
  output logic [PROC_W-1:0]                         rd_proc,
  output logic [PAGE_W-1:0]                         rd_page,
  input  logic                                      wr_en,
  input  logic [dpfm_pkg::idx_width(NUM_FRAMES)-1:0] wr_addr,
  input  logic [PROC_W-1:0]                         wr_proc,
  input  logic [PAGE_W-1:0]                         wr_page
);
  import dpfm_pkg::*;

  logic [PROC_W+PAGE_W-1:0] owner_mem [NUM_FRAMES];
  logic [PROC_W+PAGE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      owner_mem[wr_addr] <= {wr_proc, wr_page};
    end
    if (rd_en) begin
      rd_data_r <= owner_mem[rd_addr];
    end
  end

  assign rd_proc = rd_data_r[PROC_W+PAGE_W-1:PAGE_W];
  assign rd_page = rd_data_r[PAGE_W-1:0];

endmodule

>>> sv/demand_paging_fifo_mmu.sv
// ----------------------------------------------------------------------------
// demand_paging_fifo_mmu
// Per-process page tables with FIFO frame replacement.
// ----------------------------------------------------------------------------
// Output: result registered at commit, after the table read made at accept;
//   commit waits while a held result sees out_tready low, and is held meanwhile.
// Throughput: one transaction at a time, set by the read-then-write-back turn on
//   the translation table memory (read at accept, update at commit).
// Reset: synchronous rst_n clears all present bits, the fill count and the
//   replacement pointer at once; no clearing pass is needed.
module demand_paging_fifo_mmu #(
  parameter int NUM_PROCESSES     = 4,
  parameter int PAGES_PER_PROCESS = 8,
  parameter int NUM_FRAMES        = 8,
  parameter int OFFSET_BITS       = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] process_id, [4:2] virtual_page, [16:5] page_offset
  input  logic [dpfm_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [14:0] physical_address, [15] page_fault, [16] did_evict,
  // [18:17] evicted_process, [21:19] evicted_page
  output logic [dpfm_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import dpfm_pkg::*;

  localparam int NUM_ENTRIES = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int ENTRY_W     = idx_width(NUM_ENTRIES);
  localparam int PROC_W      = idx_width(NUM_PROCESSES);
  localparam int PAGE_W      = idx_width(PAGES_PER_PROCESS);
  localparam int FRAME_W     = idx_width(NUM_FRAMES);
  localparam int FILL_W      = $clog2(NUM_FRAMES + 1);

  localparam logic [OFF_W-1:0] OFF_MASK =
    (OFFSET_BITS >= OFF_W) ? {OFF_W{1'b1}} : OFF_W'((1 << OFFSET_BITS) - 1);

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_RESOLVE = 1'b1;

  in_item_t  in_item;
  out_item_t out_item;

  logic                state_r, state_nxt;
  logic [FILL_W-1:0]   filled_r, filled_nxt;
  logic [FRAME_W-1:0]  oldest_r, oldest_nxt;
  logic [ENTRY_W-1:0]  entry_r;
  logic [PROC_W-1:0]   proc_r;
  logic [PAGE_W-1:0]   page_r;
  logic [OFF_W-1:0]    offset_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r;

  logic                accept;
  logic                commit;
  logic [PID_W-1:0]    proc_red;
  logic [VPAGE_W-1:0]  page_red;
  logic [PROC_W-1:0]   proc_idx;
  logic [PAGE_W-1:0]   page_idx;
  logic [ENTRY_W-1:0]  entry_idx;

  logic                tt_present;
  logic [FRAME_W-1:0]  tt_frame;
  logic [PROC_W-1:0]   own_proc;
  logic [PAGE_W-1:0]   own_page;

  logic                miss;
  logic                evict;
  logic [FRAME_W-1:0]  frame;
  logic [ENTRY_W-1:0]  victim;
  logic [31:0]         pa_full;

  assign in_item = in_tdata;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign commit    = (state_r == ST_RESOLVE) && (!out_valid_r || out_tready);

  // Fold out-of-range process and page numbers by repeated subtraction
  always_comb begin
    proc_red = in_item.process_id;
    for (int i = 0; i < (1 << PID_W) - 1; i++) begin
      if (int'(proc_red) >= NUM_PROCESSES) begin
        proc_red = proc_red - PID_W'(NUM_PROCESSES);
      end
    end
    page_red = in_item.virtual_page;
    for (int i = 0; i < (1 << VPAGE_W) - 1; i++) begin
      if (int'(page_red) >= PAGES_PER_PROCESS) begin
        page_red = page_red - VPAGE_W'(PAGES_PER_PROCESS);
      end
    end
  end

  assign proc_idx  = PROC_W'(proc_red);
  assign page_idx  = PAGE_W'(page_red);
  assign entry_idx = ENTRY_W'(int'(proc_idx) * PAGES_PER_PROCESS + int'(page_idx));

  dpfm_table #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .FRAME_W     (FRAME_W)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr    (entry_idx),
    .rd_present (tt_present),
    .rd_frame   (tt_frame),
    .wr_en      (commit && miss),
    .wr_addr    (entry_r),
    .wr_frame   (frame),
    .clr_en     (commit && evict),
    .clr_addr   (victim)
  );

  // Owner of the replacement candidate is fetched alongside the table read
  dpfm_owner #(
    .NUM_FRAMES (NUM_FRAMES),
    .PROC_W     (PROC_W),
    .PAGE_W     (PAGE_W)
  ) u_owner (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (oldest_r),
    .rd_proc (own_proc),
    .rd_page (own_page),
    .wr_en   (commit && miss),
    .wr_addr (frame),
    .wr_proc (proc_r),
    .wr_page (page_r)
  );

  assign miss   = !tt_present;
  assign evict  = miss && (int'(filled_r) >= NUM_FRAMES);
  assign victim = ENTRY_W'(int'(own_proc) * PAGES_PER_PROCESS + int'(own_page));

  always_comb begin
    if (!miss) begin
      frame = tt_frame;
    end else if (!evict) begin
      frame = FRAME_W'(filled_r);
    end else begin
      frame = oldest_r;
    end
  end

  assign pa_full = (32'(frame) << OFFSET_BITS) | 32'(offset_r);

  always_comb begin
    out_item                  = '0;
    out_item.physical_address = pa_full[PA_W-1:0];
    out_item.page_fault       = miss;
    out_item.did_evict        = evict;
    if (evict) begin
      out_item.evicted_process = PID_W'(own_proc);
      out_item.evicted_page    = VPAGE_W'(own_page);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    oldest_nxt    = oldest_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (commit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (miss && !evict) begin
            filled_nxt = filled_r + FILL_W'(1);
          end
          if (evict) begin
            oldest_nxt = (int'(oldest_r) == NUM_FRAMES - 1) ? '0 : oldest_r + FRAME_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filled_r    <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r  <= entry_idx;
      proc_r   <= proc_idx;
      page_r   <= page_idx;
      offset_r <= in_item.page_offset & OFF_MASK;
    end
    if (commit) begin
      out_data_r <= out_item;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> verif/demand_paging_fifo_mmu_tb.sv
// ----------------------------------------------------------------------------
// demand_paging_fifo_mmu_tb
// Drives translation requests with random gaps and back-pressure, keeps a
// shadow page table with FIFO frame replacement, and checks every result
// transaction field by field against it, in order.
// ----------------------------------------------------------------------------
module demand_paging_fifo_mmu_tb;
  import dpfm_pkg::*;

  localparam int N_FRAMES    = 8;
  localparam int N_ENTRIES   = 32;
  localparam int IDLE_MAX    = 14;
  localparam int QUIET_LIMIT = 500;
  localparam int RAND_ITEMS  = 800;
  localparam int RECENT_MAX  = 12;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // shadow MMU state
  bit          page_present[N_ENTRIES];
  logic [2:0]  page_frame[N_ENTRIES];
  logic [4:0]  frame_owner[N_FRAMES];
  int unsigned frames_used;
  logic [2:0]  fifo_head;

  out_item_t   pending_xlat[$];
  logic [4:0]  recent_entries[$];
  int          errors;
  int          quiet_cycles;
  bit          gaps_on;
  bit          stalls_on;

  demand_paging_fifo_mmu dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Looks up one page and updates the shadow table the way the MMU should.
  function automatic out_item_t translate(input in_item_t req);
    out_item_t  res;
    logic [4:0] entry;
    logic [4:0] victim;
    logic [2:0] frame;
    res   = '0;
    entry = {req.process_id, req.virtual_page};
    if (page_present[entry]) begin
      frame = page_frame[entry];
    end else begin
      res.page_fault = 1'b1;
      if (frames_used < N_FRAMES) begin
        frame = frames_used[2:0];
        frames_used++;
      end else begin
        frame  = fifo_head;
        victim = frame_owner[frame];
        page_present[victim] = 1'b0;
        res.did_evict       = 1'b1;
        res.evicted_process = victim[4:3];
        res.evicted_page    = victim[2:0];
        fifo_head           = frame + 3'd1;
      end
      frame_owner[frame]  = entry;
      page_present[entry] = 1'b1;
      page_frame[entry]   = frame;
    end
    res.physical_address = {frame, req.page_offset};
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic send_translation(input logic [1:0] pid, input logic [2:0] vpage,
                                  input logic [11:0] offset);
    in_item_t req;
    int       gap;
    req              = '0;
    req.process_id   = pid;
    req.virtual_page = vpage;
    req.page_offset  = offset;
    gap = gaps_on ? $urandom_range(0, IDLE_MAX) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pending_xlat.push_back(translate(req));
    recent_entries.push_back({pid, vpage});
    if (recent_entries.size() > RECENT_MAX) void'(recent_entries.pop_front());
  endtask

  // Holds the input side off until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
  endtask

  task automatic test_cold_fill();
    // free frames go out in order; field extremes on the way
    send_translation(2'd0, 3'd0, 12'h000);
    send_translation(2'd3, 3'd7, 12'hFFF);
    send_translation(2'd1, 3'd2, 12'hAAA);
    send_translation(2'd2, 3'd5, 12'h555);
    send_translation(2'd0, 3'd7, 12'hFFF);
    send_translation(2'd3, 3'd0, 12'h000);
    send_translation(2'd1, 3'd4, 12'h800);
    send_translation(2'd2, 3'd1, 12'h001);
  endtask

  task automatic test_hits();
    send_translation(2'd0, 3'd0, 12'hFFF);
    send_translation(2'd3, 3'd7, 12'h000);
    send_translation(2'd2, 3'd1, 12'h7FF);
    send_translation(2'd2, 3'd1, 12'hFFF);
  endtask

  task automatic test_fifo_eviction();
    // table full: oldest frame goes first even if it was just hit
    send_translation(2'd1, 3'd1, 12'h123);
    send_translation(2'd0, 3'd0, 12'hFFF);
    send_translation(2'd3, 3'd7, 12'h000);
    send_translation(2'd1, 3'd1, 12'h456);
    send_translation(2'd0, 3'd0, 12'h000);
    send_translation(2'd2, 3'd5, 12'hFFF);
    send_translation(2'd1, 3'd2, 12'h0F0);
  endtask

  task automatic test_random_traffic();
    logic [4:0]  entry;
    logic [11:0] offset;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (i == RAND_ITEMS / 2) wait_drained();
      // mostly a small working set so hits and refaults mix with evictions
      if (recent_entries.size() != 0 && $urandom_range(0, 99) < 60)
        entry = recent_entries[$urandom_range(0, recent_entries.size() - 1)];
      else
        entry = 5'($urandom_range(0, N_ENTRIES - 1));
      if ($urandom_range(0, 9) == 0)
        offset = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      else
        offset = 12'($urandom_range(0, 4095));
      send_translation(entry[4:3], entry[2:0], offset);
    end
  endtask

  // result side back-pressure
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = stalls_on ? $urandom_range(0, IDLE_MAX) : 0;
      while (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        stall--;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_xlat.size() == 0) begin
          report_mismatch("result with nothing outstanding",
                          int'(got.physical_address), 0);
        end else begin
          want = pending_xlat.pop_front();
          if (got.physical_address !== want.physical_address)
            report_mismatch("physical_address", int'(got.physical_address),
                            int'(want.physical_address));
          if (got.page_fault !== want.page_fault)
            report_mismatch("page_fault", int'(got.page_fault),
                            int'(want.page_fault));
          if (got.did_evict !== want.did_evict)
            report_mismatch("did_evict", int'(got.did_evict),
                            int'(want.did_evict));
          if (got.evicted_process !== want.evicted_process)
            report_mismatch("evicted_process", int'(got.evicted_process),
                            int'(want.evicted_process));
          if (got.evicted_page !== want.evicted_page)
            report_mismatch("evicted_page", int'(got.evicted_page),
                            int'(want.evicted_page));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("demand_paging_fifo_mmu_tb NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    errors       = 0;
    quiet_cycles = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    frames_used  = 0;
    fifo_head    = '0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      page_present[i] = 1'b0;
      page_frame[i]   = '0;
    end
    for (int i = 0; i < N_FRAMES; i++) frame_owner[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_cold_fill();
    test_hits();
    test_fifo_eviction();
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("demand_paging_fifo_mmu_tb OK");
    end else begin
      $display("demand_paging_fifo_mmu_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> demand_paging_fifo_mmu.f
sv/dpfm_pkg.sv
sv/dpfm_table.sv
sv/dpfm_owner.sv
sv/demand_paging_fifo_mmu.sv
verif/demand_paging_fifo_mmu_tb.sv
